>>> sv/priority_queue_with_service_history_top_macros.svh
// Assertion macros for the priority queue with service history.
// Used by the port-level checker; expects clk and rst_n in scope.
`ifndef PRIORITY_QUEUE_WITH_SERVICE_HISTORY_TOP_MACROS_SVH
`define PRIORITY_QUEUE_WITH_SERVICE_HISTORY_TOP_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge
`define PQSH_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge
`define PQSH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/pqsh_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the priority queue with service history.
// No dependencies; imported by the wait queue, history, sequencer, top and checker.
package pqsh_pkg;

  // Request codes
  localparam logic [1:0] ACT_ENQ   = 2'd0;
  localparam logic [1:0] ACT_SERVE = 2'd1;
  localparam logic [1:0] ACT_UNDO  = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic [4:0]  LIMIT_RESET  = 5'd10;
  localparam logic [15:0] TICKET_FIRST = 16'd1;
  localparam logic [15:0] TICKET_LAST  = 16'hFFFF;

  typedef enum logic {CS_IDLE, CS_EXEC} ctl_state_t;

  // One waiting item
  typedef struct packed {
    logic [15:0] ticket;
    logic [15:0] name_ref;
    logic [15:0] complaint_ref;
  } qent_t;

  // One history record
  typedef struct packed {
    logic [15:0] ticket;
    logic [15:0] name_ref;
    logic [15:0] complaint_ref;
    logic [15:0] doctor_ref;
  } hent_t;

  // Queue memory commands
  typedef struct packed {
    logic rd_en;
    logic push;
    logic pop;
  } qcmd_t;

  // History memory commands
  typedef struct packed {
    logic rd_en;
    logic push;
    logic pop;
  } hcmd_t;

endpackage

>>> sv/pqsh_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for requests and results.
// Fixed payload widths; no package dependency.
interface pqsh_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic        urgent;
  logic [15:0] name_ref;
  logic [15:0] complaint_ref;
  logic [15:0] doctor_ref;

  modport source (output valid, action, urgent, name_ref, complaint_ref, doctor_ref,
                  input ready);
  modport sink   (input valid, action, urgent, name_ref, complaint_ref, doctor_ref,
                  output ready);
endinterface

interface pqsh_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] ticket;
  logic [15:0] out_name_ref;
  logic [15:0] out_complaint_ref;
  logic [15:0] out_doctor_ref;
  logic        from_urgent;
  logic        dropped_oldest;
  logic [4:0]  urgent_waiting;
  logic [4:0]  normal_waiting;
  logic [4:0]  history_count;

  modport source (output valid, status, ticket, out_name_ref, out_complaint_ref,
                  out_doctor_ref, from_urgent, dropped_oldest, urgent_waiting,
                  normal_waiting, history_count,
                  input ready);
  modport sink   (input valid, status, ticket, out_name_ref, out_complaint_ref,
                  out_doctor_ref, from_urgent, dropped_oldest, urgent_waiting,
                  normal_waiting, history_count,
                  output ready);
endinterface

>>> sv/pqsh_waitq.sv
`timescale 1ns / 1ps
// One FIFO wait queue: circular memory with registered read, head and count.
// Depends on pqsh_pkg.
module pqsh_waitq #(
  parameter int DEPTH = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  pqsh_pkg::qcmd_t            cmd,
  input  pqsh_pkg::qent_t            wr_data,
  output pqsh_pkg::qent_t            rd_data,
  output logic [$clog2(DEPTH+1)-1:0] count
);
  import pqsh_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;

  qent_t          mem_r [DEPTH];
  qent_t          rd_data_r;
  logic [AW-1:0]  head_r, head_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic [SW-1:0]  tail_sum;
  logic [SW-1:0]  tail_mod;
  logic [AW-1:0]  tail;

  // Tail slot: (head + count) wrapped once at the depth
  always_comb begin
    tail_sum = SW'(head_r) + SW'(count_r);
    tail_mod = (tail_sum >= SW'(DEPTH)) ? (tail_sum - SW'(DEPTH)) : tail_sum;
    tail     = tail_mod[AW-1:0];
  end

  // Pointer and occupancy update
  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    if (cmd.push) begin
      count_nxt = count_r + CW'(1);
    end
    if (cmd.pop) begin
      head_nxt  = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + AW'(1);
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  // Storage: one write port at the tail, one registered read at the head
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem_r[tail] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem_r[head_r];
    end
  end

  assign rd_data = rd_data_r;
  assign count   = count_r;

endmodule

>>> sv/pqsh_hist.sv
`timescale 1ns / 1ps
// Bounded service history: circular memory used as a stack, oldest dropped at
// the limit. Depends on pqsh_pkg.
module pqsh_hist #(
  parameter int DEPTH = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  pqsh_pkg::hcmd_t            cmd,
  input  pqsh_pkg::hent_t            wr_data,
  input  logic [4:0]                 limit,
  output pqsh_pkg::hent_t            rd_data,
  output logic [$clog2(DEPTH+1)-1:0] count,
  output logic                       at_limit
);
  import pqsh_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;
  localparam int LW = (CW > 5) ? CW : 5;

  hent_t          mem_r [DEPTH];
  hent_t          rd_data_r;
  logic [AW-1:0]  oldest_r, oldest_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic [SW-1:0]  end_sum;
  logic [SW-1:0]  end_mod;
  logic [AW-1:0]  push_slot;
  logic [AW-1:0]  top_slot;
  logic [LW-1:0]  lim_ext;
  logic [LW-1:0]  eff_limit;

  // Slot after the newest entry; the newest sits one below it
  always_comb begin
    end_sum   = SW'(oldest_r) + SW'(count_r);
    end_mod   = (end_sum >= SW'(DEPTH)) ? (end_sum - SW'(DEPTH)) : end_sum;
    push_slot = end_mod[AW-1:0];
    top_slot  = (end_mod == '0) ? AW'(DEPTH - 1) : (end_mod[AW-1:0] - AW'(1));
  end

  // Limit saturated to 1..DEPTH
  always_comb begin
    lim_ext = LW'(limit);
    if (lim_ext == '0) begin
      eff_limit = LW'(1);
    end else if (lim_ext > LW'(DEPTH)) begin
      eff_limit = LW'(DEPTH);
    end else begin
      eff_limit = lim_ext;
    end
  end

  assign at_limit = (LW'(count_r) >= eff_limit);

  // A push at the limit retires the oldest entry; the new one lands in the
  // same end slot either way
  always_comb begin
    oldest_nxt = oldest_r;
    count_nxt  = count_r;
    if (cmd.push) begin
      if (at_limit) begin
        oldest_nxt = (oldest_r == AW'(DEPTH - 1)) ? '0 : oldest_r + AW'(1);
      end else begin
        count_nxt = count_r + CW'(1);
      end
    end else if (cmd.pop) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oldest_r <= '0;
      count_r  <= '0;
    end else begin
      oldest_r <= oldest_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage: write at the end slot, registered read of the newest entry
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem_r[push_slot] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem_r[top_slot];
    end
  end

  assign rd_data = rd_data_r;
  assign count   = count_r;

endmodule

>>> sv/pqsh_ctrl.sv
`timescale 1ns / 1ps
// Request sequencer: item capture, memory commands, ticket counter, limit
// register and result register. Depends on pqsh_pkg and pqsh_if.
module pqsh_ctrl #(
  parameter int QUEUE_DEPTH   = 16,
  parameter int HISTORY_DEPTH = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [4:0]                         cfg_wdata,
  pqsh_in_if.sink                            in_ch,
  pqsh_out_if.source                         out_ch,
  output pqsh_pkg::qcmd_t                    ucmd,
  output pqsh_pkg::qcmd_t                    ncmd,
  output pqsh_pkg::qent_t                    q_wdata,
  input  pqsh_pkg::qent_t                    u_rdata,
  input  pqsh_pkg::qent_t                    n_rdata,
  input  logic [$clog2(QUEUE_DEPTH+1)-1:0]   u_count,
  input  logic [$clog2(QUEUE_DEPTH+1)-1:0]   n_count,
  output pqsh_pkg::hcmd_t                    hcmd,
  output pqsh_pkg::hent_t                    h_wdata,
  input  pqsh_pkg::hent_t                    h_rdata,
  input  logic [$clog2(HISTORY_DEPTH+1)-1:0] h_count,
  input  logic                               h_at_limit,
  output logic [4:0]                         limit
);
  import pqsh_pkg::*;

  localparam int QCW = $clog2(QUEUE_DEPTH + 1);
  localparam int HCW = $clog2(HISTORY_DEPTH + 1);

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] ticket;
    logic [15:0] name_ref;
    logic [15:0] complaint_ref;
    logic [15:0] doctor_ref;
    logic        from_urgent;
    logic        dropped_oldest;
    logic [4:0]  urgent_waiting;
    logic [4:0]  normal_waiting;
    logic [4:0]  history_count;
  } res_t;

  ctl_state_t     state_r, state_nxt;
  logic           ovalid_r, ovalid_nxt;
  res_t           res_r, res_nxt;
  logic [15:0]    ticket_r, ticket_nxt;
  logic [4:0]     limit_r;
  logic [1:0]     act_r;
  logic           urg_r;
  logic [15:0]    name_r;
  logic [15:0]    compl_r;
  logic [15:0]    doc_r;
  logic           in_xfer;
  logic           finish;
  qent_t          served;
  logic [QCW-1:0] u_after, n_after;
  logic [HCW-1:0] h_after;

  assign in_ch.ready = (state_r == CS_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  // Result register free, or being emptied this cycle
  assign finish      = (state_r == CS_EXEC) && (!ovalid_r || out_ch.ready);
  assign served      = (u_count != '0) ? u_rdata : n_rdata;

  // Request capture
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      act_r   <= in_ch.action;
      urg_r   <= in_ch.urgent;
      name_r  <= in_ch.name_ref;
      compl_r <= in_ch.complaint_ref;
      doc_r   <= in_ch.doctor_ref;
    end
  end

  // Sequencer: read on transfer, modify and write back in the execute state once the result register is free
  always_comb begin
    state_nxt  = state_r;
    ovalid_nxt = ovalid_r && !out_ch.ready;
    res_nxt    = res_r;
    ticket_nxt = ticket_r;
    ucmd       = '0;
    ncmd       = '0;
    hcmd       = '0;
    q_wdata    = '{ticket: ticket_r, name_ref: name_r, complaint_ref: compl_r};
    h_wdata    = '{ticket: served.ticket, name_ref: served.name_ref,
                   complaint_ref: served.complaint_ref, doctor_ref: doc_r};
    u_after    = u_count;
    n_after    = n_count;
    h_after    = h_count;

    case (state_r)
      CS_IDLE: begin
        if (in_xfer) begin
          ucmd.rd_en = 1'b1;
          ncmd.rd_en = 1'b1;
          hcmd.rd_en = 1'b1;
          state_nxt  = CS_EXEC;
        end
      end
      CS_EXEC: begin
        if (finish) begin
          state_nxt      = CS_IDLE;
          ovalid_nxt     = 1'b1;
          res_nxt        = '0;
          res_nxt.status = ST_EMPTY;
          case (act_r)
            ACT_ENQ: begin
              if (urg_r ? (u_count == QCW'(QUEUE_DEPTH)) : (n_count == QCW'(QUEUE_DEPTH)))
              begin
                res_nxt.status = ST_FULL;
              end else begin
                if (urg_r) begin
                  ucmd.push = 1'b1;
                  u_after   = u_count + QCW'(1);
                end else begin
                  ncmd.push = 1'b1;
                  n_after   = n_count + QCW'(1);
                end
                res_nxt.status = ST_OK;
                res_nxt.ticket = ticket_r;
                ticket_nxt     = (ticket_r == TICKET_LAST) ? TICKET_FIRST : ticket_r + 16'd1;
              end
            end
            ACT_SERVE: begin
              if (u_count != '0 || n_count != '0) begin
                if (u_count != '0) begin
                  ucmd.pop            = 1'b1;
                  u_after             = u_count - QCW'(1);
                  res_nxt.from_urgent = 1'b1;
                end else begin
                  ncmd.pop = 1'b1;
                  n_after  = n_count - QCW'(1);
                end
                hcmd.push              = 1'b1;
                h_after                = h_at_limit ? h_count : h_count + HCW'(1);
                res_nxt.status         = ST_OK;
                res_nxt.ticket         = served.ticket;
                res_nxt.name_ref       = served.name_ref;
                res_nxt.complaint_ref  = served.complaint_ref;
                res_nxt.doctor_ref     = doc_r;
                res_nxt.dropped_oldest = h_at_limit;
              end
            end
            ACT_UNDO: begin
              if (h_count != '0) begin
                hcmd.pop              = 1'b1;
                h_after               = h_count - HCW'(1);
                res_nxt.status        = ST_OK;
                res_nxt.ticket        = h_rdata.ticket;
                res_nxt.name_ref      = h_rdata.name_ref;
                res_nxt.complaint_ref = h_rdata.complaint_ref;
                res_nxt.doctor_ref    = h_rdata.doctor_ref;
              end
            end
            default: begin
              res_nxt.status = ST_EMPTY;
            end
          endcase
          res_nxt.urgent_waiting = 5'(u_after);
          res_nxt.normal_waiting = 5'(n_after);
          res_nxt.history_count  = 5'(h_after);
        end
      end
      default: begin
        state_nxt = CS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= CS_IDLE;
      ovalid_r <= 1'b0;
      ticket_r <= TICKET_FIRST;
      limit_r  <= LIMIT_RESET;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
      ticket_r <= ticket_nxt;
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign limit                    = limit_r;
  assign out_ch.valid             = ovalid_r;
  assign out_ch.status            = res_r.status;
  assign out_ch.ticket            = res_r.ticket;
  assign out_ch.out_name_ref      = res_r.name_ref;
  assign out_ch.out_complaint_ref = res_r.complaint_ref;
  assign out_ch.out_doctor_ref    = res_r.doctor_ref;
  assign out_ch.from_urgent       = res_r.from_urgent;
  assign out_ch.dropped_oldest    = res_r.dropped_oldest;
  assign out_ch.urgent_waiting    = res_r.urgent_waiting;
  assign out_ch.normal_waiting    = res_r.normal_waiting;
  assign out_ch.history_count     = res_r.history_count;

endmodule

>>> sv/priority_queue_with_service_history_top.sv
`timescale 1ns / 1ps
// Two-level strict priority queue with a bounded service history.
//
// Channels: in_ch takes requests (enqueue, serve, undo) with their handles;
// out_ch returns one result per request with status, ticket, handles and the
// occupancies after the request. Both are valid/ready; a transfer happens on
// a rising edge with valid and ready high. cfg_we/cfg_wdata set the history
// limit (saturated to 1..HISTORY_DEPTH); the user must write it only while no
// request is in flight, which the block itself does not enforce.
// The transfer edge reads both queue heads and the newest history entry; in
// the execute state the block writes back to the queue and history memories
// and loads the result register, from which the result then transfers.
// A new request is not taken until the last one has left the execute state.
// The result register lets a new request transfer while a result waits; if
// out_ch stalls, the following request holds in the write-back cycle until
// the result register is free.
// Reset clears queue and history pointers, sets the next ticket to 1 and the
// limit to 10; memory contents are not cleared and need no clearing pass.
// Depends on pqsh_pkg, pqsh_if, pqsh_waitq, pqsh_hist and pqsh_ctrl.
module priority_queue_with_service_history_top #(
  parameter int QUEUE_DEPTH   = 16,
  parameter int HISTORY_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [4:0] cfg_wdata,
  pqsh_in_if.sink    in_ch,
  pqsh_out_if.source out_ch
);
  import pqsh_pkg::*;

  localparam int QCW = $clog2(QUEUE_DEPTH + 1);
  localparam int HCW = $clog2(HISTORY_DEPTH + 1);

  qcmd_t          ucmd, ncmd;
  hcmd_t          hcmd;
  qent_t          q_wdata, u_rdata, n_rdata;
  hent_t          h_wdata, h_rdata;
  logic [QCW-1:0] u_count, n_count;
  logic [HCW-1:0] h_count;
  logic           h_at_limit;
  logic [4:0]     limit;

  // Urgent wait queue
  pqsh_waitq #(.DEPTH(QUEUE_DEPTH)) u_urgent_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (ucmd),
    .wr_data (q_wdata),
    .rd_data (u_rdata),
    .count   (u_count)
  );

  // Normal wait queue
  pqsh_waitq #(.DEPTH(QUEUE_DEPTH)) u_normal_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (ncmd),
    .wr_data (q_wdata),
    .rd_data (n_rdata),
    .count   (n_count)
  );

  // Service history
  pqsh_hist #(.DEPTH(HISTORY_DEPTH)) u_hist (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (hcmd),
    .wr_data  (h_wdata),
    .limit    (limit),
    .rd_data  (h_rdata),
    .count    (h_count),
    .at_limit (h_at_limit)
  );

  // Sequencer and result register
  pqsh_ctrl #(
    .QUEUE_DEPTH   (QUEUE_DEPTH),
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .ucmd       (ucmd),
    .ncmd       (ncmd),
    .q_wdata    (q_wdata),
    .u_rdata    (u_rdata),
    .n_rdata    (n_rdata),
    .u_count    (u_count),
    .n_count    (n_count),
    .hcmd       (hcmd),
    .h_wdata    (h_wdata),
    .h_rdata    (h_rdata),
    .h_count    (h_count),
    .h_at_limit (h_at_limit),
    .limit      (limit)
  );

endmodule

>>> sv/pqsh_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the priority queue top, attached by bind.
// Depends on pqsh_pkg and the assertion macro header.
`include "priority_queue_with_service_history_top_macros.svh"

module pqsh_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  status,
  input logic [15:0] ticket,
  input logic        from_urgent,
  input logic        dropped_oldest
);
  import pqsh_pkg::*;

  // A request holds the sequencer in its execute state: no transfer straight after another
  `PQSH_ASSERT_NEXT(a_two_cycle_issue, in_valid && in_ready, !in_ready,
                    "request accepted on consecutive cycles")

  // A stalled result stays offered
  `PQSH_ASSERT_NEXT(a_out_held, out_valid && !out_ready, out_valid,
                    "result withdrawn while stalled")

  // Failed requests carry no ticket and no serve flags
  `PQSH_ASSERT_SAME(a_fail_clean, out_valid && status != ST_OK,
                    ticket == 16'd0 && !from_urgent && !dropped_oldest,
                    "failed result carries ticket or flags")

  // Tickets in use are never zero
  `PQSH_ASSERT_SAME(a_ok_ticket, out_valid && status == ST_OK, ticket != 16'd0,
                    "successful result with zero ticket")

endmodule

bind priority_queue_with_service_history_top pqsh_checker u_pqsh_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .status         (out_ch.status),
  .ticket         (out_ch.ticket),
  .from_urgent    (out_ch.from_urgent),
  .dropped_oldest (out_ch.dropped_oldest)
);
